FILE: src/deque_with_search_unit_macros.svh
// Assertion helpers for the checker file.
`ifndef DEQUE_WITH_SEARCH_UNIT_MACROS_SVH
`define DEQUE_WITH_SEARCH_UNIT_MACROS_SVH

// Plain property, sampled on the rising clock, off while reset is low
`define DQS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define DQS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  `DQS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication
`define DQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `DQS_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: src/dqs_pkg.sv
package dqs_pkg;

  // Storage geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned OCC_W  = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = OP_W'(0);
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_POP_FRONT  = OP_W'(2);
  localparam logic [OP_W-1:0] OP_POP_BACK   = OP_W'(3);
  localparam logic [OP_W-1:0] OP_SEARCH     = OP_W'(4);

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = ST_W'(0);
  localparam logic [ST_W-1:0] ST_EMPTY = ST_W'(1);
  localparam logic [ST_W-1:0] ST_FULL  = ST_W'(2);

  // Per-cell control from the top level
  typedef struct packed {
    logic shift_r;  // take left neighbor (push at front)
    logic shift_l;  // take right neighbor (pop at front)
    logic load;     // take push data (push at back lands here)
    logic held;     // cell holds a live entry
  } cell_ctrl_t;

endpackage

FILE: src/dqs_ifs.sv
// Request channel: operation and value
interface dqs_req_if;
  import dqs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;
  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// Response channel: status, found flag, occupancy
interface dqs_rsp_if;
  import dqs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic             found;
  logic [OCC_W-1:0] occupancy;
  modport source (output valid, output status, output found, output occupancy, input ready);
  modport sink   (input valid, input status, input found, input occupancy, output ready);
endinterface

FILE: src/dqs_cell.sv
module dqs_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dqs_pkg::cell_ctrl_t              ctrl_i,
  input  logic signed [dqs_pkg::DATA_W-1:0] left_i,
  input  logic signed [dqs_pkg::DATA_W-1:0] right_i,
  input  logic signed [dqs_pkg::DATA_W-1:0] push_data_i,
  input  logic signed [dqs_pkg::DATA_W-1:0] key_i,
  input  logic                             tok_i,
  input  logic                             hit_i,
  output logic signed [dqs_pkg::DATA_W-1:0] entry_o,
  output logic                             tok_o,
  output logic                             hit_o
);
  import dqs_pkg::*;

  logic signed [DATA_W-1:0] entry_q, entry_d;
  logic                     tok_q, hit_q, hit_d;

  // Entry update: shift toward back, shift toward front, or load
  always_comb begin
    if (ctrl_i.shift_r) begin
      entry_d = left_i;
    end else if (ctrl_i.shift_l) begin
      entry_d = right_i;
    end else if (ctrl_i.load) begin
      entry_d = push_data_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Search token passes one cell per cycle, carrying the running hit
  assign hit_d = tok_i & (hit_i | (ctrl_i.held & (entry_q == key_i)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
      hit_q <= hit_d;
    end
  end

  assign entry_o = entry_q;
  assign tok_o   = tok_q;
  assign hit_o   = hit_q;

endmodule

FILE: src/deque_with_search_unit.sv
// Channel  Dir  Modport  Payload                          Transaction when
// req_i    in   sink     operation[2:0], value[31:0] s    valid & ready
// rsp_o    out  source   status[1:0], found, occupancy[4:0] valid & ready
//
// Entries live in a row of DEPTH cells; the front entry is always cell 0.
// The response to a push or pop is registered on acceptance.
// A search walks a token along the cell row, one compare per cell per cycle.
// One transaction in flight; a new request is taken while the response
// register empties. Reset clears the count and the control; entries are not.
module deque_with_search_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  dqs_req_if.sink   req_i,
  dqs_rsp_if.source rsp_o
);
  import dqs_pkg::*;

  logic                     req_fire, rsp_fire;
  logic                     busy_q, start_q;
  logic signed [DATA_W-1:0] key_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [ST_W-1:0]          status_d;
  logic                     full, empty, is_search, search_done;

  logic                     rsp_valid_q;
  logic [ST_W-1:0]          status_q;
  logic                     found_q;
  logic [OCC_W-1:0]         occ_q;

  cell_ctrl_t               ctrl [DEPTH];
  logic signed [DATA_W-1:0] entry [DEPTH];
  logic                     tok [DEPTH];
  logic                     hit [DEPTH];

  assign req_i.ready = !busy_q && (!rsp_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid & req_i.ready;
  assign rsp_fire    = rsp_valid_q & rsp_o.ready;

  assign full        = (count_q == CNT_W'(DEPTH));
  assign empty       = (count_q == '0);
  assign is_search   = (req_i.operation == OP_SEARCH);
  assign search_done = tok[DEPTH-1];

  // Status and next count for one operation
  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    unique case (req_i.operation) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        count_d  = count_q;
        status_d = ST_OK;
      end
    endcase
  end

  // Control: count, busy flag, search launch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      start_q <= 1'b0;
    end else begin
      if (req_fire) begin
        count_q <= count_d;
      end
      start_q <= req_fire & is_search;
      if (req_fire && is_search) begin
        busy_q <= 1'b1;
      end else if (search_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && is_search) begin
      key_q <= req_i.value;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if ((req_fire && !is_search) || search_done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_fire) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && !is_search) begin
      status_q <= status_d;
      found_q  <= 1'b0;
      occ_q    <= OCC_W'(count_d);
    end else if (search_done) begin
      status_q <= ST_OK;
      found_q  <= hit[DEPTH-1];
      occ_q    <= OCC_W'(count_q);
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.found     = found_q;
  assign rsp_o.occupancy = occ_q;

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w;
    logic                     tok_in, hit_in;

    assign ctrl[i].shift_r = req_fire && (req_i.operation == OP_PUSH_FRONT) && !full;
    assign ctrl[i].shift_l = req_fire && (req_i.operation == OP_POP_FRONT) && !empty;
    assign ctrl[i].load    = req_fire && (req_i.operation == OP_PUSH_BACK) && !full &&
                             (count_q == CNT_W'(i));
    assign ctrl[i].held    = (count_q > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_w = req_i.value;
      assign tok_in = start_q;
      assign hit_in = 1'b0;
    end else begin : g_body
      assign left_w = entry[i-1];
      assign tok_in = tok[i-1];
      assign hit_in = hit[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_w = entry[i];
    end else begin : g_inner
      assign right_w = entry[i+1];
    end

    dqs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl[i]),
      .left_i      (left_w),
      .right_i     (right_w),
      .push_data_i (req_i.value),
      .key_i       (key_q),
      .tok_i       (tok_in),
      .hit_i       (hit_in),
      .entry_o     (entry[i]),
      .tok_o       (tok[i]),
      .hit_o       (hit[i])
    );
  end

endmodule

FILE: src/dqs_checker.sv
`include "deque_with_search_unit_macros.svh"

module dqs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [dqs_pkg::ST_W-1:0]   rsp_status_i,
  input logic                       rsp_found_i,
  input logic [dqs_pkg::OCC_W-1:0]  rsp_occupancy_i
);
  import dqs_pkg::*;

  // No new request while a response is held back
  `DQS_ASSERT_IMPLY(a_no_req_on_stall, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, !req_ready_i, "request taken while response stalled")

  // A hit only comes with an ok status
  `DQS_ASSERT_IMPLY(a_found_ok, clk_i, rst_ni, rsp_valid_i && rsp_found_i, rsp_status_i == ST_OK, "found set with non-ok status")

  // Occupancy never exceeds the capacity
  `DQS_ASSERT_IMPLY(a_occ_bound, clk_i, rst_ni, rsp_valid_i, (DEPTH > 31) || (rsp_occupancy_i <= OCC_W'(DEPTH)), "occupancy above capacity")

  // Stalled response holds
  `DQS_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_found_i) && $stable(rsp_occupancy_i), "stalled response changed")

  // A request stall with no response pending is never preceded by a stalled response
  `DQS_ASSERT_IMPLY(a_req_quiet_busy, clk_i, rst_ni, req_valid_i && !req_ready_i && !rsp_valid_i, !$past(rsp_valid_i && !rsp_ready_i), "request stalled right after a response stall ended")

endmodule

bind deque_with_search_unit dqs_checker u_dqs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_status_i    (rsp_o.status),
  .rsp_found_i     (rsp_o.found),
  .rsp_occupancy_i (rsp_o.occupancy)
);
